// File: rtl/nbm_pkg.sv
// ----------------------------------------------------------------------------
// nbm_pkg: shared definitions for the normal basis GF(2^m) multiplier
// Field sizes, item layouts and operation codes used across the rtl folder.
// ----------------------------------------------------------------------------
package nbm_pkg;

  localparam int unsigned MaxDegree   = 64;
  localparam int unsigned TableDepth  = 2 * MaxDegree - 1;
  localparam int unsigned WordW       = 64;
  localparam int unsigned DegreeW     = 7;
  localparam int unsigned IndexW      = 7;
  localparam int unsigned PartnerW    = 6;

  localparam logic [DegreeW-1:0] DegreeReset = 7'd14;

  // operation codes of an input item
  localparam logic OpTableWrite = 1'b0;
  localparam logic OpMultiply   = 1'b1;

  typedef struct packed {
    logic                op;
    logic [IndexW-1:0]   table_index;
    logic [PartnerW-1:0] table_value;
    logic [WordW-1:0]    operand_a;
    logic [WordW-1:0]    operand_b;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] product;
  } out_item_t;

  typedef struct packed {
    logic [DegreeW-1:0] field_degree;
  } cfg_item_t;

endpackage

// File: rtl/nbm_stream_if.sv
// ----------------------------------------------------------------------------
// nbm_stream_if: valid/ready channel
// One item moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface nbm_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// File: rtl/nbm_ram.sv
// ----------------------------------------------------------------------------
// nbm_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/normal_basis_gf2m_multiplier_top.sv
// ----------------------------------------------------------------------------
// normal_basis_gf2m_multiplier_top: Massey-Omura multiplier, GF(2^m)
// Normal basis multiplier driven by a partner table held in a small RAM.
// ----------------------------------------------------------------------------
// Usage
//   in_i  : items with op = table write (fill one partner entry) or multiply.
//   out_o : one product item per multiply; table writes give no item.
//   cfg_i : field degree m, always ready, write only while the block is idle.
//           Values outside 2..64 saturate into that range.
// Timing
//   A table write leaves the block idle, so in_i stays ready for the next item.
//   A multiply walks the 2m-1 table entries, one per cycle, through a single
//   shared term unit (rotate a, barrel shift b, AND, XOR into the product).
//   After the last entry a hold state loads the product into the output
//   register once it is free; only then is a new item taken. The table RAM
//   read port sets the one-entry-per-cycle pace.
// Reset and stall
//   Reset sets m to 14 and empties the output register. The table is not
//   cleared: every entry a multiply reads must have been written first.
//   A stalled receiver holds the product in the output register; the next
//   item may still be accepted and worked on, and waits for the register.
// ----------------------------------------------------------------------------
module normal_basis_gf2m_multiplier_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  nbm_stream_if.sink   in_i,
  nbm_stream_if.source out_o,
  nbm_stream_if.sink   cfg_i
);

  localparam int unsigned W  = nbm_pkg::WordW;
  localparam int unsigned DW = nbm_pkg::DegreeW;
  localparam int unsigned IW = nbm_pkg::IndexW;
  localparam int unsigned PW = nbm_pkg::PartnerW;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StHold
  } state_e;

  state_e         state_q, state_d;
  logic [DW-1:0]  degree_q;       // configured field degree
  logic [DW-1:0]  m_q, m_d;       // degree latched for the multiply
  logic [W-1:0]   mask_q, mask_d;
  logic [W-1:0]   topbit_q, topbit_d;
  logic [W-1:0]   a_rot_q, a_rot_d;
  logic [2*W-1:0] bb_q, bb_d;     // b repeated twice for modulo-m rotation
  logic [W-1:0]   acc_q, acc_d;
  logic [IW-1:0]  t_q, t_d;
  logic [IW-1:0]  last_q, last_d;
  logic [W-1:0]   product_q, product_d;
  logic           out_valid_q, out_valid_d;

  logic           in_acc;
  logic [DW-1:0]  m_eff, m_dec;
  logic [W-1:0]   mask_eff, a_m, b_m;
  logic [2*W-1:0] b_ext, bb_shift;
  logic [W-1:0]   b_rot, a_next;
  logic           ram_we;
  logic [IW-1:0]  ram_raddr;
  logic [PW-1:0]  ram_rdata;

  // partner table
  nbm_ram #(
    .Width (PW),
    .Depth (nbm_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.payload.table_index),
    .wdata_i (in_i.payload.table_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_i.ready   = 1'b1;
  assign in_i.ready    = (state_q == StIdle);
  assign in_acc        = in_i.valid & in_i.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload.product = product_q;

  // saturate degree into 2..MaxDegree
  always_comb begin
    if (degree_q < DW'(2)) begin
      m_eff = DW'(2);
    end else if (degree_q > DW'(nbm_pkg::MaxDegree)) begin
      m_eff = DW'(nbm_pkg::MaxDegree);
    end else begin
      m_eff = degree_q;
    end
  end

  assign m_dec    = m_eff - DW'(1);
  assign mask_eff = ~({W{1'b1}} << m_eff);
  assign a_m      = in_i.payload.operand_a & mask_eff;
  assign b_m      = in_i.payload.operand_b & mask_eff;
  assign b_ext    = {{W{1'b0}}, b_m};

  // term unit: b rotated by the partner, a rotated by one place mod m
  assign bb_shift = bb_q >> ram_rdata;
  assign b_rot    = bb_shift[W-1:0];
  assign a_next   = (a_rot_q >> 1) | (a_rot_q[0] ? topbit_q : '0);

  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    mask_d      = mask_q;
    topbit_d    = topbit_q;
    a_rot_d     = a_rot_q;
    bb_d        = bb_q;
    acc_d       = acc_q;
    t_d         = t_q;
    last_d      = last_q;
    product_d   = product_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_raddr   = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_i.payload.op == nbm_pkg::OpTableWrite) begin
            ram_we = (in_i.payload.table_index < IW'(nbm_pkg::TableDepth));
          end else begin
            m_d      = m_eff;
            mask_d   = mask_eff;
            topbit_d = W'(1) << m_dec;
            a_rot_d  = a_m;
            bb_d     = b_ext | (b_ext << m_eff);
            acc_d    = '0;
            t_d      = '0;
            last_d   = {m_dec[IW-2:0], 1'b0};
            state_d  = StRun;
          end
        end
      end
      StRun: begin
        // entries of m or more add nothing
        if ({1'b0, ram_rdata} < m_q) begin
          acc_d = acc_q ^ (a_rot_q & b_rot);
        end
        // a index (t+1)/2 steps after every even t
        if (!t_q[0]) begin
          a_rot_d = a_next;
        end
        if (t_q == last_q) begin
          state_d = StHold;
        end else begin
          t_d       = t_q + IW'(1);
          ram_raddr = t_q + IW'(1);
        end
      end
      StHold: begin
        if (!out_valid_q || out_o.ready) begin
          product_d   = acc_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      degree_q    <= nbm_pkg::DegreeReset;
      m_q         <= nbm_pkg::DegreeReset;
      mask_q      <= '0;
      t_q         <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      m_q         <= m_d;
      mask_q      <= mask_d;
      t_q         <= t_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        degree_q <= cfg_i.payload.field_degree;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    topbit_q  <= topbit_d;
    a_rot_q   <= a_rot_d;
    bb_q      <= bb_d;
    acc_q     <= acc_d;
    product_q <= product_d;
  end

  // rotation of a inside m bits keeps its weight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |=> ($countones(a_rot_q) == $past($countones(a_rot_q))))
    else $error("a rotation lost or gained bits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (t_q <= last_q))
    else $error("term counter ran past last entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.payload.op == nbm_pkg::OpMultiply)) |=> !in_i.ready)
    else $error("input taken during multiply");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> ((out_o.payload.product & ~mask_q) == '0))
    else $error("product bits set at or above m");

endmodule

// File: tb/normal_basis_gf2m_multiplier_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// normal_basis_gf2m_multiplier_top_tb: self-checking bench for the multiplier
// Fills the partner table, runs directed and random multiplies at several
// field degrees (saturating ones included) under varying idle and stall
// patterns, and checks every product against an in-bench predictor.
// ----------------------------------------------------------------------------
module normal_basis_gf2m_multiplier_top_tb;

  localparam int unsigned WordW      = nbm_pkg::WordW;
  localparam int unsigned DegreeW    = nbm_pkg::DegreeW;
  localparam int unsigned IndexW     = nbm_pkg::IndexW;
  localparam int unsigned PartnerW   = nbm_pkg::PartnerW;
  localparam int unsigned MaxDegree  = nbm_pkg::MaxDegree;
  localparam int unsigned TableDepth = nbm_pkg::TableDepth;

  // Generous watchdog: the slowest run is well under half of this.
  localparam int unsigned ClockLimit  = 2_000_000;
  // One full multiply at the largest degree plus margin.
  localparam int unsigned DrainCycles = 2 * MaxDegree + 40;

  logic clk;
  logic rst_n;

  nbm_stream_if #(.payload_t(nbm_pkg::in_item_t))  in_if ();
  nbm_stream_if #(.payload_t(nbm_pkg::out_item_t)) out_if ();
  nbm_stream_if #(.payload_t(nbm_pkg::cfg_item_t)) cfg_if ();

  normal_basis_gf2m_multiplier_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Items waiting to go to the block, and products we expect back.
  nbm_pkg::in_item_t   pending_items[$];
  logic [WordW-1:0]    expected_products[$];

  // Shadow of the block's state, updated on accepted items.
  logic [PartnerW-1:0] partner_shadow [TableDepth];
  logic [DegreeW-1:0]  degree_shadow;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        in_taken;

  int unsigned cfg_writes;
  int unsigned table_writes;
  int unsigned products_checked;
  int unsigned mismatches;
  int unsigned cycle_count;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  // Out-of-range degrees saturate into 2..MaxDegree.
  function automatic int unsigned active_degree();
    int unsigned d;
    d = 32'(degree_shadow);
    if (d < 2) d = 2;
    if (d > MaxDegree) d = MaxDegree;
    return d;
  endfunction

  // Massey-Omura product: bit k is the XOR over table entries t of
  // a[(t+1)/2 + k] & b[T[t] + k], indices mod m. Entries of m or more drop out.
  function automatic logic [WordW-1:0] nb_product(logic [WordW-1:0] a,
                                                 logic [WordW-1:0] b);
    int unsigned m;
    int unsigned ap;
    int unsigned bp;
    int unsigned partner;
    logic        acc;
    logic [WordW-1:0] prod;
    m    = active_degree();
    prod = '0;
    for (int unsigned k = 0; k < m; k++) begin
      acc = 1'b0;
      for (int unsigned t = 0; t < 2 * m - 1; t++) begin
        partner = 32'(partner_shadow[t[IndexW-1:0]]);
        if (partner < m) begin
          ap  = ((t + 1) / 2 + k) % m;
          bp  = (partner + k) % m;
          acc = acc ^ (a[ap[5:0]] & b[bp[5:0]]);
        end
      end
      prod[k[5:0]] = acc;
    end
    return prod;
  endfunction

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------
  function automatic nbm_pkg::in_item_t table_item(int unsigned idx, int unsigned val);
    nbm_pkg::in_item_t it;
    it.op          = nbm_pkg::OpTableWrite;
    it.table_index = IndexW'(idx);
    it.table_value = PartnerW'(val);
    // unused operand bits toggle too
    it.operand_a   = {$urandom, $urandom};
    it.operand_b   = {$urandom, $urandom};
    return it;
  endfunction

  function automatic nbm_pkg::in_item_t mult_item(logic [WordW-1:0] a,
                                                  logic [WordW-1:0] b);
    nbm_pkg::in_item_t it;
    it.op          = nbm_pkg::OpMultiply;
    it.table_index = IndexW'($urandom_range(127));
    it.table_value = PartnerW'($urandom_range(63));
    it.operand_a   = a;
    it.operand_b   = b;
    return it;
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    logic [WordW-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(5))
      0: begin
        w = 64'd1 << $urandom_range(63);
      end
      1: begin
        w = '1;
      end
      2: begin
        w = w & {$urandom, $urandom};
      end
      3: begin
        w = ~(64'd1 << $urandom_range(63));
      end
      default: ;
    endcase
    return w;
  endfunction

  // Writes every entry a multiply at degree m reads, so nothing unwritten
  // is ever used. Mostly live partners, some large ones that drop out.
  task automatic queue_table_fill(int unsigned m);
    int unsigned val;
    for (int unsigned t = 0; t < 2 * m - 1; t++) begin
      val = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(m - 1);
      pending_items.push_back(table_item(t, val));
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: new item on the falling edge once the previous one has gone
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_if.valid || in_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.payload <= pending_items.pop_front();
        in_if.valid   <= 1'b1;
      end else begin
        in_if.valid   <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and scoreboard: everything sampled on the rising edge.
  // Output check comes first so a push at the same edge never confuses it.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [WordW-1:0] want,
                                 logic [WordW-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at cycle %0d: expected %h, got %h (m=%0d)",
               what, cycle_count, want, got, active_degree());
    end
  endtask

  always @(posedge clk) begin : scoreboard
    logic [WordW-1:0] want;
    in_taken <= in_if.valid && in_if.ready;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_products.size() == 0) begin
          report_mismatch("unexpected product", '0, out_if.payload.product);
        end else begin
          want = expected_products.pop_front();
          products_checked++;
          if (out_if.payload.product !== want) begin
            report_mismatch("product mismatch", want, out_if.payload.product);
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        degree_shadow = cfg_if.payload.field_degree;
        cfg_writes++;
      end
      if (in_if.valid && in_if.ready) begin
        if (in_if.payload.op == nbm_pkg::OpMultiply) begin
          expected_products.push_back(nb_product(in_if.payload.operand_a,
                                                 in_if.payload.operand_b));
        end else begin
          // index TableDepth and above is dropped by the block
          if (in_if.payload.table_index < IndexW'(TableDepth)) begin
            partner_shadow[in_if.payload.table_index] = in_if.payload.table_value;
          end
          table_writes++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= ClockLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  // Block idle: queue drained, nothing in flight, all products back, then
  // enough cycles for a trailing table write to settle.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_if.valid || expected_products.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_degree(logic [DegreeW-1:0] d);
    int unsigned seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_if.payload.field_degree <= d;
    cfg_if.valid                <= 1'b1;
    do @(negedge clk);
    while (cfg_writes == seen);
    cfg_if.valid <= 1'b0;
  endtask

  // One phase: new degree, fresh table, then random traffic. Most items are
  // multiplies; the rest rewrite entries so the table changes under load.
  task automatic run_phase(logic [DegreeW-1:0] d, int unsigned send_pct,
                           int unsigned recv_pct, int unsigned count);
    int unsigned m;
    int unsigned done;
    int unsigned idx;
    int unsigned val;
    wait_quiet();
    write_degree(d);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    m = active_degree();
    queue_table_fill(m);
    done = 0;
    while (done < count) begin
      if ($urandom_range(99) < 85) begin
        pending_items.push_back(mult_item(rand_word(), rand_word()));
        done++;
      end else begin
        idx = $urandom_range(127);
        val = ($urandom_range(99) < 70) ? $urandom_range(m - 1) : $urandom_range(63);
        pending_items.push_back(table_item(idx, val));
        if (idx < TableDepth) done++;
      end
    end
  endtask

  initial begin
    logic [WordW-1:0] low_mask;
    clk_init : begin end
    rst_n          = 1'b0;
    in_taken       = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cfg_writes       = 0;
    table_writes     = 0;
    products_checked = 0;
    mismatches       = 0;
    cycle_count      = 0;
    degree_shadow    = nbm_pkg::DegreeReset;
    for (int t = 0; t < TableDepth; t++) partner_shadow[t[IndexW-1:0]] = '0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset degree, no register write yet.
    low_mask = (64'd1 << nbm_pkg::DegreeReset) - 1;
    queue_table_fill(32'(nbm_pkg::DegreeReset));
    pending_items.push_back(mult_item('0, '0));
    pending_items.push_back(mult_item('1, '1));
    pending_items.push_back(mult_item('1, '0));
    pending_items.push_back(mult_item('0, '1));
    pending_items.push_back(mult_item(64'd1, 64'd1));
    pending_items.push_back(mult_item(64'd1 << (nbm_pkg::DegreeReset - 1),
                                      64'd1 << (nbm_pkg::DegreeReset - 1)));
    // only bits at or above m set: must come out as zero
    pending_items.push_back(mult_item(~low_mask, ~low_mask));
    pending_items.push_back(mult_item(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa));
    // index past the table end is dropped
    pending_items.push_back(table_item(127, 5));
    pending_items.push_back(mult_item({$urandom, $urandom}, {$urandom, $urandom}));
    // large entries: the top value, and exactly m
    pending_items.push_back(table_item(3, 63));
    pending_items.push_back(table_item(4, 32'(nbm_pkg::DegreeReset)));
    pending_items.push_back(mult_item('1, {$urandom, $urandom}));
    pending_items.push_back(mult_item({$urandom, $urandom}, '1));
    pending_items.push_back(table_item(3, 0));
    pending_items.push_back(table_item(4, 32'(nbm_pkg::DegreeReset) - 1));
    pending_items.push_back(mult_item({$urandom, $urandom}, {$urandom, $urandom}));

    // Random phases: extremes and saturating degrees, then mostly small
    // fields; each idle pattern appears at least once.
    run_phase(7'd2,   0,  0,  100);
    run_phase(7'd0,   77, 0,  60);
    run_phase(7'd64,  0,  0,  40);
    run_phase(7'd127, 32, 32, 30);
    run_phase(7'd1,   0,  77, 60);
    run_phase(DegreeW'($urandom_range(3, 20)), 77, 0,  130);
    run_phase(DegreeW'($urandom_range(2, 32)), 0,  77, 130);
    run_phase(DegreeW'($urandom_range(5, 40)), 32, 32, 130);
    run_phase(DegreeW'($urandom_range(2, 16)), 0,  0,  130);

    wait_quiet();

    $display("Checked %0d products and %0d table writes over %0d degree writes,",
             products_checked, table_writes, cfg_writes);
    $display("degrees 2 to 64 incl. saturating values, with idle and stall mixes.");
    if (mismatches == 0 && expected_products.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
